// ===== hdl/npcs_pkg.sv =====
package npcs_pkg;

  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;
  localparam int TAG_W  = 16;
  localparam int IDX_W  = 8;
  localparam int DIST_W = 29;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  // Query transaction as it travels down the cell chain, with the best match so far.
  typedef struct packed {
    logic                     valid;
    logic                     have;
    logic signed [LAT_W-1:0]  qlat;
    logic signed [LON_W-1:0]  qlon;
    logic [DIST_W-1:0]        best_dist;
    logic [IDX_W-1:0]         idx;
    logic [TAG_W-1:0]         tag;
  } token_t;

endpackage

// ===== hdl/npcs_if.sv =====
interface npcs_cmd_if;
  import npcs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic signed [LAT_W-1:0] lat;
  logic signed [LON_W-1:0] lon;
  logic [TAG_W-1:0]        tag;

  modport source (output valid, output op, output lat, output lon, output tag, input ready);
  modport sink   (input valid, input op, input lat, input lon, input tag, output ready);
endinterface

interface npcs_res_if;
  import npcs_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [TAG_W-1:0]  nearest_tag;
  logic [IDX_W-1:0]  nearest_index;
  logic [DIST_W-1:0] distance;

  modport source (output valid, output found, output nearest_tag, output nearest_index,
                  output distance, input ready);
  modport sink   (input valid, input found, input nearest_tag, input nearest_index,
                  input distance, output ready);
endinterface

// ===== hdl/npcs_cell.sv =====
module npcs_cell #(
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic signed [npcs_pkg::LAT_W-1:0] wr_lat,
  input  logic signed [npcs_pkg::LON_W-1:0] wr_lon,
  input  logic [npcs_pkg::TAG_W-1:0]        wr_tag,
  input  logic                             active,
  input  npcs_pkg::token_t                 tok_in,
  output npcs_pkg::token_t                 tok_out
);
  import npcs_pkg::*;

  logic signed [LAT_W-1:0] lat;
  logic signed [LON_W-1:0] lon;
  logic [TAG_W-1:0]        tag;
  token_t                  tok;
  token_t                  tok_next;

  logic signed [LAT_W:0] dlat;
  logic signed [LON_W:0] dlon;
  logic [DIST_W-1:0]     alat;
  logic [DIST_W-1:0]     alon;
  logic [DIST_W-1:0]     d;
  logic                  take;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lat <= wr_lat;
      lon <= wr_lon;
      tag <= wr_tag;
    end
  end

  always_comb begin
    dlat = {tok_in.qlat[LAT_W-1], tok_in.qlat} - {lat[LAT_W-1], lat};
    dlon = {tok_in.qlon[LON_W-1], tok_in.qlon} - {lon[LON_W-1], lon};
    alat = dlat[LAT_W] ? DIST_W'(-dlat) : DIST_W'(dlat);
    alon = dlon[LON_W] ? DIST_W'(-dlon) : DIST_W'(dlon);
    d    = (alat > alon) ? alat : alon;
    // strict compare keeps the earliest entry on a tie
    take = tok_in.valid && active && (!tok_in.have || (d < tok_in.best_dist));

    tok_next = tok_in;
    if (take) begin
      tok_next.have      = 1'b1;
      tok_next.best_dist = d;
      tok_next.idx       = IDX_W'(INDEX);
      tok_next.tag       = tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_next;
    end
  end

  assign tok_out = tok;

endmodule

// ===== hdl/nearest_point_chebyshev_search.sv =====
// Nearest stored point by Chebyshev distance, max(|dlat|, |dlon|).
// cmd channel: op selects append (store lat/lon/tag at the end of the table),
//   clear (empty the table) or query (search for the nearest point to lat/lon).
//   Appends to a full table and the unused op code are accepted and dropped.
// res channel: one transaction per query with found, nearest_tag,
//   nearest_index and distance; found=0 with zero fields on an empty table.
// Each table entry lives in one cell of a chain of TABLE_DEPTH cells. A query
//   walks the chain one cell per cycle carrying the best match so far, and the
//   last cell's match is then captured in the output register.
// cmd.ready is low from query acceptance until its result has been taken, so
//   only one query is in flight at a time.
// If res.ready is low, the result is held in the output register and cmd
//   stays stalled until the result is taken.
// Reset empties the table and drops any query in flight.
module nearest_point_chebyshev_search #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  npcs_cmd_if.sink   cmd,
  npcs_res_if.source res
);
  import npcs_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             busy;
  logic             busy_next;
  logic             res_valid;
  logic             res_valid_next;
  logic             cmd_acc;
  logic             is_append;
  logic             is_query;

  token_t           tok [0:TABLE_DEPTH];
  token_t           last;

  logic              found;
  logic [TAG_W-1:0]  nearest_tag;
  logic [IDX_W-1:0]  nearest_index;
  logic [DIST_W-1:0] distance;

  assign cmd.ready = !busy && !res_valid;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign is_append = cmd_acc && (cmd.op == OP_APPEND);
  assign is_query  = cmd_acc && (cmd.op == OP_QUERY);
  assign last      = tok[TABLE_DEPTH];

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = is_query;
    tok[0].qlat  = cmd.lat;
    tok[0].qlon  = cmd.lon;
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    npcs_cell #(
      .INDEX (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (is_append && (count == CNT_W'(k))),
      .wr_lat  (cmd.lat),
      .wr_lon  (cmd.lon),
      .wr_tag  (cmd.tag),
      .active  (count > CNT_W'(k)),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  always_comb begin
    count_next = count;
    if (cmd_acc) begin
      case (cmd.op)
        OP_APPEND: begin
          if (count < CNT_W'(TABLE_DEPTH)) begin
            count_next = count + CNT_W'(1);
          end
        end
        OP_CLEAR: count_next = '0;
        default:  count_next = count;
      endcase
    end
  end

  always_comb begin
    busy_next = busy;
    if (is_query) begin
      busy_next = 1'b1;
    end else if (last.valid) begin
      busy_next = 1'b0;
    end

    res_valid_next = res_valid;
    if (last.valid) begin
      res_valid_next = 1'b1;
    end else if (res.ready) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      count     <= count_next;
      busy      <= busy_next;
      res_valid <= res_valid_next;
    end
  end

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (last.valid) begin
      found         <= last.have;
      nearest_tag   <= last.tag;
      nearest_index <= last.idx;
      distance      <= last.best_dist;
    end
  end

  assign res.valid         = res_valid;
  assign res.found         = found;
  assign res.nearest_tag   = nearest_tag;
  assign res.nearest_index = nearest_index;
  assign res.distance      = distance;

endmodule

// ===== test/nearest_point_chebyshev_search_test.sv =====
module nearest_point_chebyshev_search_test;
  import npcs_pkg::*;

  localparam int DEPTH          = 256;
  localparam int ITEM_TARGET    = 700;
  localparam int TAIL_ITEMS     = 100;
  localparam int LONG_STALL     = 700;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int LAT_LO = -(2 ** (LAT_W - 1));
  localparam int LAT_HI = 2 ** (LAT_W - 1) - 1;
  localparam int LON_LO = -(2 ** (LON_W - 1));
  localparam int LON_HI = 2 ** (LON_W - 1) - 1;

  typedef struct {
    logic [1:0]              code;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic [TAG_W-1:0]        tag;
    bit                      drain_first;
  } command_t;

  typedef struct packed {
    logic              found;
    logic [TAG_W-1:0]  tag;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
  } nearest_t;

  logic clk = 1'b0;
  logic rst;

  npcs_cmd_if cmd_bus ();
  npcs_res_if res_bus ();

  nearest_point_chebyshev_search #(.TABLE_DEPTH(DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Point table as the block should hold it.
  logic signed [LAT_W-1:0] site_lat [DEPTH];
  logic signed [LON_W-1:0] site_lon [DEPTH];
  logic [TAG_W-1:0]        site_tag [DEPTH];
  int                      site_count;

  command_t cmd_backlog [$];
  nearest_t nearest_due [$];
  command_t next_cmd;

  // Stimulus planning state.
  int plan_lat [$];
  int plan_lon [$];
  int planned_items;
  int cmd_total;

  int  cmds_accepted;
  int  mismatches;
  int  cycle_count;
  int  quiet_cycles;
  int  gap_left;
  int  stall_left;
  int  answers_checked;
  bit  long_stall_done;

  function automatic bit idling_on();
    return cmd_backlog.size() > TAIL_ITEMS && (cycle_count % 3000) < 2000;
  endfunction

  // Update the table and, for a query, predict the nearest point.
  task automatic track_command(logic [1:0] code, logic signed [LAT_W-1:0] qlat,
                               logic signed [LON_W-1:0] qlon, logic [TAG_W-1:0] qtag);
    nearest_t ans;
    longint   dlat;
    longint   dlon;
    longint   d;
    case (code)
      OP_APPEND: begin
        if (site_count < DEPTH) begin
          site_lat[site_count] = qlat;
          site_lon[site_count] = qlon;
          site_tag[site_count] = qtag;
          site_count++;
        end
      end
      OP_CLEAR: site_count = 0;
      OP_QUERY: begin
        ans = '0;
        for (int i = 0; i < site_count; i++) begin
          dlat = longint'(qlat) - longint'(site_lat[i]);
          dlon = longint'(qlon) - longint'(site_lon[i]);
          if (dlat < 0) dlat = -dlat;
          if (dlon < 0) dlon = -dlon;
          d = (dlat > dlon) ? dlat : dlon;
          // strict compare: the earliest entry keeps a tie
          if (!ans.found || d < longint'(ans.distance)) begin
            ans.found    = 1'b1;
            ans.tag      = site_tag[i];
            ans.index    = i[IDX_W-1:0];
            ans.distance = d[DIST_W-1:0];
          end
        end
        nearest_due.push_back(ans);
      end
      default: ;
    endcase
  endtask

  task automatic report(string field, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  task automatic add_cmd(logic [1:0] code, int la, int lo, int tg, bit drain);
    command_t c;
    c.code        = code;
    c.lat         = la[LAT_W-1:0];
    c.lon         = lo[LON_W-1:0];
    c.tag         = tg[TAG_W-1:0];
    c.drain_first = drain;
    cmd_backlog.push_back(c);
    case (code)
      OP_APPEND: begin
        if (plan_lat.size() < DEPTH) begin
          plan_lat.push_back(la);
          plan_lon.push_back(lo);
          planned_items++;
        end
      end
      OP_CLEAR: begin
        plan_lat.delete();
        plan_lon.delete();
        planned_items++;
      end
      OP_QUERY: planned_items++;
      default: ;
    endcase
  endtask

  function automatic int pick_lat();
    if ($urandom_range(0, 7) == 0) return $urandom();
    return $urandom_range(0, 180000000) - 90000000;
  endfunction

  function automatic int pick_lon();
    if ($urandom_range(0, 7) == 0) return $urandom();
    return $urandom_range(0, 360000000) - 180000000;
  endfunction

  function automatic int jitter(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic add_directed();
    add_cmd(OP_QUERY, 0, 0, $urandom_range(0, 65535), 1'b0);      // empty table
    add_cmd(OP_APPEND, 90000000, -180000000, 16'hFFFF, 1'b0);
    add_cmd(OP_APPEND, -90000000, 180000000, 16'h0000, 1'b0);
    add_cmd(OP_APPEND, LAT_HI, LON_LO, 16'h5A5A, 1'b0);
    add_cmd(OP_APPEND, LAT_LO, LON_HI, 16'hA5A5, 1'b0);
    add_cmd(OP_APPEND, 1000, 1000, 16'h1234, 1'b0);
    add_cmd(OP_APPEND, 1000, 1000, 16'h4321, 1'b0);               // duplicate point
    add_cmd(OP_QUERY, 1000, 1000, 16'hFFFF, 1'b0);
    add_cmd(OP_QUERY, LAT_LO, LON_LO, 0, 1'b0);
    add_cmd(OP_QUERY, LAT_HI, LON_HI, 0, 1'b0);
    add_cmd(OP_QUERY, 90000000, -180000000, 0, 1'b0);
    add_cmd(OP_APPEND, 1500, 500, 16'h0F0F, 1'b0);
    add_cmd(OP_QUERY, 1250, 750, 0, 1'b0);                        // equal distance to two
    add_cmd(OP_UNUSED, $urandom(), $urandom(), $urandom(), 1'b0);
    add_cmd(OP_QUERY, 0, 0, 0, 1'b0);
    add_cmd(OP_CLEAR, $urandom(), $urandom(), $urandom(), 1'b1);
    add_cmd(OP_QUERY, 0, 0, 0, 1'b0);
    add_cmd(OP_APPEND, 0, LON_HI, 16'h0001, 1'b0);
    add_cmd(OP_QUERY, LAT_LO, LON_LO, 0, 1'b0);                   // widest distance
    add_cmd(OP_CLEAR, 0, 0, 0, 1'b0);
  endtask

  task automatic add_full_table();
    add_cmd(OP_CLEAR, $urandom(), $urandom(), $urandom(), 1'b1);
    repeat (DEPTH + 3) add_cmd(OP_APPEND, pick_lat(), pick_lon(), $urandom_range(0, 65535),
                               1'b0);
    repeat (3) add_cmd(OP_QUERY, pick_lat(), pick_lon(), $urandom_range(0, 65535), 1'b0);
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 6))
      add_cmd(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(), 1'b0);
  endtask

  task automatic add_cluster();
    int clat;
    int clon;
    int k;
    clat = pick_lat();
    clon = pick_lon();
    if ($urandom_range(0, 2) == 0)
      add_cmd(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom_range(0, 3) == 0);
    repeat ($urandom_range(1, 24)) begin
      if (plan_lat.size() > 0 && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, plan_lat.size() - 1);
        add_cmd(OP_APPEND, plan_lat[k], plan_lon[k], $urandom_range(0, 65535), 1'b0);
      end else begin
        add_cmd(OP_APPEND, clat + jitter(1000), clon + jitter(1000),
                $urandom_range(0, 65535), 1'b0);
      end
    end
    repeat ($urandom_range(1, 6)) begin
      k = $urandom_range(0, plan_lat.size() - 1);
      case ($urandom_range(0, 3))
        0: add_cmd(OP_QUERY, plan_lat[k], plan_lon[k], $urandom(), 1'b0);
        1: add_cmd(OP_QUERY, plan_lat[k] + jitter(300), plan_lon[k] + jitter(300),
                   $urandom(), 1'b0);
        2: add_cmd(OP_QUERY, clat, clon, $urandom(), 1'b0);
        default: add_cmd(OP_QUERY, pick_lat(), pick_lon(), $urandom(), 1'b0);
      endcase
    end
  endtask

  initial begin
    bit full_done;
    rst               = 1'b1;
    cmd_bus.valid     = 1'b0;
    cmd_bus.op        = '0;
    cmd_bus.lat       = '0;
    cmd_bus.lon       = '0;
    cmd_bus.tag       = '0;
    res_bus.ready     = 1'b0;
    full_done         = 1'b0;
    add_directed();
    while (planned_items < ITEM_TARGET) begin
      if (!full_done && planned_items >= 300) begin
        add_full_table();
        full_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        add_noise();
      end else begin
        add_cluster();
      end
    end
    cmd_total = cmd_backlog.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (cmds_accepted < cmd_total) @(posedge clk);
    while (nearest_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        track_command(cmd_bus.op, cmd_bus.lat, cmd_bus.lon, cmd_bus.tag);
        cmds_accepted++;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_bus.valid <= 1'b0;
        end else if (cmd_backlog.size() == 0 ||
                     (cmd_backlog[0].drain_first && nearest_due.size() != 0)) begin
          cmd_bus.valid <= 1'b0;
        end else begin
          next_cmd = cmd_backlog.pop_front();
          cmd_bus.valid <= 1'b1;
          cmd_bus.op    <= next_cmd.code;
          cmd_bus.lat   <= next_cmd.lat;
          cmd_bus.lon   <= next_cmd.lon;
          cmd_bus.tag   <= next_cmd.tag;
          if (idling_on() && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 19);
        end
      end
    end
  end

  // Result monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (nearest_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tag %0d index %0d",
                   $time, res_bus.nearest_tag, res_bus.nearest_index);
          mismatches++;
        end else begin
          if (res_bus.found !== nearest_due[0].found)
            report("found", nearest_due[0].found, res_bus.found);
          if (res_bus.nearest_tag !== nearest_due[0].tag)
            report("nearest_tag", nearest_due[0].tag, res_bus.nearest_tag);
          if (res_bus.nearest_index !== nearest_due[0].index)
            report("nearest_index", nearest_due[0].index, res_bus.nearest_index);
          if (res_bus.distance !== nearest_due[0].distance)
            report("distance", nearest_due[0].distance, res_bus.distance);
          void'(nearest_due.pop_front());
        end
        answers_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (!long_stall_done && answers_checked == 12) begin
        // hold off long enough for the command side to back up
        long_stall_done = 1'b1;
        stall_left = LONG_STALL - 1;
        res_bus.ready <= 1'b0;
      end else if (idling_on() && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up when neither channel moves a transaction for too long
  always @(posedge clk) begin
    cycle_count++;
    if (!rst) begin
      if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
